// File: hw/rtl/scan_obstacle_segmenter_macros.svh
// assertion macros for the scan obstacle segmenter
// expects signals named clock and reset in the including module
`ifndef SCAN_OBSTACLE_SEGMENTER_MACROS_SVH
`define SCAN_OBSTACLE_SEGMENTER_MACROS_SVH

// same-cycle implication, checked outside reset
`define SOS_ASSERT_HOLDS(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define SOS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/sos_pkg.sv
// shared types and constants of the scan obstacle segmenter
// no dependencies
`timescale 1ns / 1ps

package sos_pkg;

   localparam int MAX_POINTS = 1024;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = 11;
   localparam int RANGE_W    = 16;
   localparam int QUAL_W     = 4;
   localparam int LIMIT_W    = RANGE_W + 1;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int NUM_SLOTS  = 3;
   localparam int SLOT_CNT_W = 2;

   localparam logic [RANGE_W-1:0] SEP_OUTDOOR_MM = RANGE_W'(600);
   localparam logic [RANGE_W-1:0] SEP_INDOOR_MM  = RANGE_W'(200);

   localparam logic [RANGE_W-1:0] RST_MAX_RANGE_MM   = RANGE_W'(8000);
   localparam logic [QUAL_W-1:0]  RST_ROUGH_LEVEL    = QUAL_W'(2);
   localparam logic [CNT_W-1:0]   RST_POINT_COUNT    = CNT_W'(181);

   localparam logic KIND_OBSTACLE = 1'b0;
   localparam logic KIND_DITCH    = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MAX_RANGE_RIGHT = 3'd0,
      REG_MAX_RANGE_LEFT  = 3'd1,
      REG_SEARCH_EXT      = 3'd2,
      REG_MIN_RANGE       = 3'd3,
      REG_OUTDOOR_MODE    = 3'd4,
      REG_HORIZONTAL_SCAN = 3'd5,
      REG_ROUGH_LEVEL     = 3'd6,
      REG_POINT_COUNT     = 3'd7
   } sos_reg_type;

   typedef struct packed {
      logic [RANGE_W-1:0] range_mm;
      logic [QUAL_W-1:0]  quality;
      logic               point_valid;
   } sos_req_type;

   typedef struct packed {
      logic [IDX_W-1:0] first_index;
      logic [IDX_W-1:0] last_index;
      logic             kind;
      logic             last_of_run;
   } sos_rsp_type;

   typedef struct packed {
      logic [RANGE_W-1:0] max_range_right_mm;
      logic [RANGE_W-1:0] max_range_left_mm;
      logic [RANGE_W-1:0] search_extension_mm;
      logic [RANGE_W-1:0] min_range_mm;
      logic               outdoor_mode;
      logic               horizontal_scan;
      logic [QUAL_W-1:0]  rough_level;
      logic [CNT_W-1:0]   point_count;
   } sos_cfg_type;

   // up to three results of one point, packed from slot 0
   typedef struct packed {
      logic                             load;
      logic [SLOT_CNT_W-1:0]            count;
      sos_rsp_type [NUM_SLOTS-1:0]      slot;
   } sos_bundle_type;

endpackage

// File: hw/rtl/sos_csr.sv
// configuration registers of the scan obstacle segmenter
// depends on sos_pkg
`timescale 1ns / 1ps

module sos_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [sos_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sos_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output sos_pkg::sos_cfg_type               cfg
);
   import sos_pkg::*;

   sos_cfg_type cfg_ff;
   sos_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_MAX_RANGE_RIGHT: cfg_in.max_range_right_mm  = csr_wdata[RANGE_W-1:0];
            REG_MAX_RANGE_LEFT:  cfg_in.max_range_left_mm   = csr_wdata[RANGE_W-1:0];
            REG_SEARCH_EXT:      cfg_in.search_extension_mm = csr_wdata[RANGE_W-1:0];
            REG_MIN_RANGE:       cfg_in.min_range_mm        = csr_wdata[RANGE_W-1:0];
            REG_OUTDOOR_MODE:    cfg_in.outdoor_mode        = csr_wdata[0];
            REG_HORIZONTAL_SCAN: cfg_in.horizontal_scan     = csr_wdata[0];
            REG_ROUGH_LEVEL:     cfg_in.rough_level         = csr_wdata[QUAL_W-1:0];
            REG_POINT_COUNT:     cfg_in.point_count         = csr_wdata[CNT_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_range_right_mm  <= RST_MAX_RANGE_MM;
         cfg_ff.max_range_left_mm   <= RST_MAX_RANGE_MM;
         cfg_ff.search_extension_mm <= '0;
         cfg_ff.min_range_mm        <= '0;
         cfg_ff.outdoor_mode        <= 1'b0;
         cfg_ff.horizontal_scan     <= 1'b0;
         cfg_ff.rough_level         <= RST_ROUGH_LEVEL;
         cfg_ff.point_count         <= RST_POINT_COUNT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: hw/rtl/sos_seg.sv
// input register, scan state and per-point segmentation logic
// depends on sos_pkg
`timescale 1ns / 1ps

module sos_seg (
   input  logic                    clock,
   input  logic                    reset,
   input  sos_pkg::sos_cfg_type    cfg,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  sos_pkg::sos_req_type    req_data,
   input  logic                    bnd_ready,
   output sos_pkg::sos_bundle_type bnd
);
   import sos_pkg::*;

   logic               in_valid_ff, in_valid_in;
   sos_req_type        in_data_ff, in_data_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               obst_ff, obst_in;
   logic [IDX_W-1:0]   start_ff, start_in;
   logic [RANGE_W-1:0] prev_range_ff, prev_range_in;
   logic [QUAL_W-1:0]  prev_qual_ff, prev_qual_in;

   logic               advance, accept;
   logic [CNT_W-1:0]   cnt_eff, half;
   logic [IDX_W-1:0]   last_idx, idx_prev;
   logic               is_last, right_half;
   logic [RANGE_W-1:0] rng, p_rng, sep, lim_sel;
   logic [QUAL_W-1:0]  q, p_q;
   logic [LIMIT_W-1:0] limit, d_up, d_dn;
   logic               rough, jump_up, jump_dn, below, above, start_ok;
   logic               got_end, ditch, obst_mid, fin;
   logic [IDX_W-1:0]   start_mid;
   sos_rsp_type        ent_d, ent_e, ent_f;

   assign advance   = in_valid_ff && bnd_ready;
   assign req_stall = in_valid_ff && !bnd_ready;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = accept || (in_valid_ff && !advance);
      in_data_in  = accept ? req_data : in_data_ff;
   end

   // scan length clamp and position
   always_comb begin
      if (cfg.point_count == '0) begin
         cnt_eff = CNT_W'(1);
      end else if (cfg.point_count > CNT_W'(MAX_POINTS)) begin
         cnt_eff = CNT_W'(MAX_POINTS);
      end else begin
         cnt_eff = cfg.point_count;
      end
      last_idx   = IDX_W'(cnt_eff - CNT_W'(1));
      half       = cnt_eff >> 1;
      is_last    = idx_ff >= last_idx;
      right_half = CNT_W'(idx_ff) < half;
      idx_prev   = idx_ff - IDX_W'(1);
   end

   always_comb begin
      rng     = in_data_ff.range_mm;
      q       = in_data_ff.quality;
      // first point of a scan compares with itself
      p_rng   = (idx_ff == '0) ? rng : prev_range_ff;
      p_q     = (idx_ff == '0) ? q : prev_qual_ff;
      sep     = cfg.outdoor_mode ? SEP_OUTDOOR_MM : SEP_INDOOR_MM;
      lim_sel = right_half ? cfg.max_range_right_mm : cfg.max_range_left_mm;
      limit   = LIMIT_W'(lim_sel) + LIMIT_W'(cfg.search_extension_mm);
      rough   = q >= cfg.rough_level;
      d_up    = LIMIT_W'(rng) - LIMIT_W'(p_rng);
      d_dn    = LIMIT_W'(p_rng) - LIMIT_W'(rng);
      // a negative difference shows as a set top bit
      jump_up = !d_up[LIMIT_W-1] && (d_up[RANGE_W-1:0] > sep);
      jump_dn = !d_dn[LIMIT_W-1] && (d_dn[RANGE_W-1:0] > sep);
      below   = LIMIT_W'(rng) < limit;
      above   = LIMIT_W'(rng) > limit;

      start_ok = rough && below && in_data_ff.point_valid && (rng > cfg.min_range_mm);
      got_end  = obst_ff && (!rough || above || jump_up || jump_dn || is_last ||
                             !in_data_ff.point_valid);
      ditch    = cfg.outdoor_mode && !cfg.horizontal_scan &&
                 ((!rough && jump_dn && (LIMIT_W'(p_rng) < limit)) ||
                  ((p_q < cfg.rough_level) && jump_up && below));

      obst_mid  = (obst_ff && !got_end) ? 1'b1 : start_ok;
      start_mid = (obst_ff && !got_end) ? start_ff : idx_ff;
      fin       = is_last && obst_mid;
   end

   // candidate results, packed in order ditch, closed interval, open at scan end
   always_comb begin
      ent_d = '{first_index: idx_prev, last_index: idx_ff,
                kind: KIND_DITCH, last_of_run: 1'b0};
      ent_e = '{first_index: start_ff, last_index: idx_prev,
                kind: KIND_OBSTACLE, last_of_run: 1'b0};
      ent_f = '{first_index: start_mid, last_index: last_idx,
                kind: KIND_OBSTACLE, last_of_run: 1'b0};

      bnd.load    = advance;
      bnd.count   = SLOT_CNT_W'(ditch) + SLOT_CNT_W'(got_end) + SLOT_CNT_W'(fin);
      bnd.slot[0] = ditch ? ent_d : (got_end ? ent_e : ent_f);
      bnd.slot[1] = (ditch && got_end) ? ent_e : ent_f;
      bnd.slot[2] = ent_f;
   end

   always_comb begin
      idx_in        = idx_ff;
      obst_in       = obst_ff;
      start_in      = start_ff;
      prev_range_in = prev_range_ff;
      prev_qual_in  = prev_qual_ff;
      if (advance) begin
         idx_in        = is_last ? '0 : idx_ff + IDX_W'(1);
         obst_in       = is_last ? 1'b0 : obst_mid;
         start_in      = is_last ? '0 : start_mid;
         prev_range_in = rng;
         prev_qual_in  = q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         idx_ff        <= '0;
         obst_ff       <= 1'b0;
         start_ff      <= '0;
         prev_range_ff <= '0;
         prev_qual_ff  <= '0;
      end else begin
         in_valid_ff   <= in_valid_in;
         idx_ff        <= idx_in;
         obst_ff       <= obst_in;
         start_ff      <= start_in;
         prev_range_ff <= prev_range_in;
         prev_qual_ff  <= prev_qual_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff <= in_data_in;
   end

endmodule

// File: hw/rtl/sos_out.sv
// result buffer: holds the results of one point and hands them out in order
// depends on sos_pkg
`timescale 1ns / 1ps

module sos_out (
   input  logic                    clock,
   input  logic                    reset,
   input  sos_pkg::sos_bundle_type bnd,
   output logic                    bnd_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output sos_pkg::sos_rsp_type    rsp_data
);
   import sos_pkg::*;

   logic [SLOT_CNT_W-1:0]       rem_ff, rem_in;
   sos_rsp_type [NUM_SLOTS-1:0] slot_ff, slot_in;
   logic                        pop;

   assign rsp_valid = rem_ff != '0;
   assign pop       = rsp_valid && !rsp_stall;
   // free now, or the last held result leaves in this cycle
   assign bnd_ready = (rem_ff == '0) || ((rem_ff == SLOT_CNT_W'(1)) && !rsp_stall);

   always_comb begin
      rem_in  = rem_ff;
      slot_in = slot_ff;
      if (bnd.load) begin
         rem_in  = bnd.count;
         slot_in = bnd.slot;
      end else if (pop) begin
         rem_in     = rem_ff - SLOT_CNT_W'(1);
         slot_in[0] = slot_ff[1];
         slot_in[1] = slot_ff[2];
         slot_in[2] = slot_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
      end else begin
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   always_comb begin
      rsp_data             = slot_ff[0];
      rsp_data.last_of_run = rem_ff == SLOT_CNT_W'(1);
   end

endmodule

// File: hw/rtl/scan_obstacle_segmenter.sv
// Scan obstacle segmenter: groups rough, valid, in-range scan points into
// obstacle intervals and reports ditch edges in outdoor, non-horizontal scans.
// Input: one scan point per req_ transfer (range, quality, valid flag),
// points of a scan in order from right to left; the scan length comes from
// the point count register. Output: zero to three rsp_ transfers per point,
// each an index pair with its kind; last_of_run marks the final one of a point.
// Points pass the input register, then the result buffer. One point per cycle
// while each gives at most one result and rsp_ is not stalled; a point giving
// more holds the result port until its last result leaves. The input register
// takes a new point while results still wait on rsp_. Registers are written
// through csr_we/csr_index/csr_wdata by the user only while idle, unenforced by
// the block. Reset clears the registers to their defaults, empties both stages
// and restarts the scan at point zero. A stalled rsp_ keeps its result steady;
// req_stall rises once the input register and the result buffer are both full.
// Depends on sos_pkg, sos_csr, sos_seg, sos_out and the macros header.
`timescale 1ns / 1ps
`include "scan_obstacle_segmenter_macros.svh"

module scan_obstacle_segmenter (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  sos_pkg::sos_req_type           req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output sos_pkg::sos_rsp_type           rsp_data,
   input  logic                           csr_we,
   input  logic [sos_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sos_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import sos_pkg::*;

   sos_cfg_type    cfg;
   sos_bundle_type bnd;
   logic           bnd_ready;

   sos_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sos_seg u_seg (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .bnd_ready (bnd_ready),
      .bnd       (bnd)
   );

   sos_out u_out (
      .clock     (clock),
      .reset     (reset),
      .bnd       (bnd),
      .bnd_ready (bnd_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // a held result must never be overwritten by the next point
   `SOS_ASSERT_HOLDS(a_no_load_on_stall, rsp_valid && rsp_stall, !bnd.load, "results overwritten while stalled")
   // more results of the same point must follow a non-final one
   `SOS_ASSERT_NEXT(a_run_continues, rsp_valid && !rsp_data.last_of_run, rsp_valid, "result run cut short")
   // a ditch edge pair always spans two neighboring points
   `SOS_ASSERT_HOLDS(a_ditch_pair, rsp_valid && (rsp_data.kind == KIND_DITCH), rsp_data.last_index == IDX_W'(rsp_data.first_index + IDX_W'(1)), "ditch pair not adjacent")

endmodule

// File: tb/sv/scan_obstacle_segmenter_tb.sv
// self-checking bench for scan_obstacle_segmenter: a directed table, then random scans
// checks each result against the table or a local predictor; needs sos_pkg and the rtl
`timescale 1ns / 1ps

module scan_obstacle_segmenter_tb;
   import sos_pkg::*;

   localparam int HALF_PERIOD   = 10;
   localparam int SETTLE_CYCLES = 6;
   localparam int HOLD_CYCLES   = 200;
   localparam int IDLE_LIMIT    = 4000;
   localparam int TARGET_POINTS = 380;
   localparam int PRINT_CAP     = 40;
   localparam int FROM_MODEL    = -1;

   typedef enum logic { ROW_CSR, ROW_POINT } row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      sos_reg_type  csr;
      logic [15:0]  value;
      sos_req_type  pt;
      int           typed_n;
      sos_rsp_type  typed_seg;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   sos_req_type           req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   sos_rsp_type           rsp_data;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // predictor copy of the registers and the scan state
   sos_cfg_type           seg_cfg;
   logic [IDX_W-1:0]      scan_pos;
   logic [IDX_W-1:0]      run_first;
   logic                  run_open;
   logic [RANGE_W-1:0]    last_range;
   logic [QUAL_W-1:0]     last_quality;
   sos_rsp_type           seg_buf [0:NUM_SLOTS-1];

   sos_rsp_type           expected_segments [$];
   stim_row_type          directed_rows [$];
   int                    fail_count = 0;
   int                    points_sent = 0;
   int                    idle_cycles = 0;
   bit                    sender_steady = 1'b0;
   bit                    hold_request = 1'b0;
   int                    walk_range = 1000;
   bit                    walk_rough = 1'b0;

   scan_obstacle_segmenter uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      if (fail_count < PRINT_CAP)
         $display("[%0t] mismatch: %s", $time, msg);
      fail_count++;
   endtask

   function automatic sos_rsp_type segment(input logic [IDX_W-1:0] first,
                                           input logic [IDX_W-1:0] last,
                                           input logic kind);
      sos_rsp_type s;
      s.first_index = first;
      s.last_index  = last;
      s.kind        = kind;
      s.last_of_run = 1'b0;
      return s;
   endfunction

   // works out the results of one point into seg_buf and advances the scan state
   task automatic segment_point(input sos_req_type pt, output int n);
      int cnt, idx, rng, prev_rng, prev_q, lim, sep, diff;
      bit is_last, rough, start_ok, closes, ditch;
      cnt = int'(seg_cfg.point_count);
      if (cnt == 0) cnt = 1;
      if (cnt > MAX_POINTS) cnt = MAX_POINTS;
      idx = int'(scan_pos);
      rng = int'(pt.range_mm);
      is_last = (idx >= cnt - 1);
      // first point of a scan is compared with itself
      prev_rng = (idx == 0) ? rng : int'(last_range);
      prev_q = (idx == 0) ? int'(pt.quality) : int'(last_quality);
      lim = ((idx >= cnt / 2) ? int'(seg_cfg.max_range_left_mm)
                              : int'(seg_cfg.max_range_right_mm))
            + int'(seg_cfg.search_extension_mm);
      sep = seg_cfg.outdoor_mode ? int'(SEP_OUTDOOR_MM) : int'(SEP_INDOOR_MM);
      rough = (pt.quality >= seg_cfg.rough_level);
      diff = rng - prev_rng;
      start_ok = rough && (rng < lim) && pt.point_valid && (rng > int'(seg_cfg.min_range_mm));
      closes = 1'b0;
      n = 0;
      if (!run_open) begin
         run_open = start_ok;
         run_first = scan_pos;
      end else begin
         closes = !rough || (rng > lim) || (diff > sep) || (-diff > sep) || is_last ||
                  !pt.point_valid;
      end
      if (seg_cfg.outdoor_mode && !seg_cfg.horizontal_scan) begin
         ditch = (!rough && (-diff > sep) && (prev_rng < lim)) ||
                 ((prev_q < int'(seg_cfg.rough_level)) && (diff > sep) && (rng < lim));
         if (ditch) begin
            seg_buf[n] = segment(scan_pos - 1'b1, scan_pos, KIND_DITCH);
            n++;
         end
      end
      if (closes) begin
         seg_buf[n] = segment(run_first, scan_pos - 1'b1, KIND_OBSTACLE);
         n++;
         run_open = start_ok;
         run_first = scan_pos;
      end
      if (is_last) begin
         if (run_open) begin
            seg_buf[n] = segment(run_first, IDX_W'(cnt - 1), KIND_OBSTACLE);
            n++;
         end
         scan_pos = '0;
         run_open = 1'b0;
         run_first = '0;
      end else begin
         scan_pos = scan_pos + 1'b1;
      end
      last_range = pt.range_mm;
      last_quality = pt.quality;
      if (n > 0) seg_buf[n-1].last_of_run = 1'b1;
   endtask

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [15:0] pick_limit();
      case ($urandom_range(0, 9))
         0: return 16'd0;
         1: return 16'hFFFF;
         2, 3: return 16'($urandom_range(0, 65535));
         default: return 16'($urandom_range(1500, 9000));
      endcase
   endfunction

   // random walk in range with runs of rough and smooth quality, and some random points
   function automatic sos_req_type next_scan_point();
      sos_req_type pt;
      int reach, floor_mm, roll, step, lvl;
      reach = int'(seg_cfg.max_range_right_mm) + int'(seg_cfg.search_extension_mm);
      if (reach > 65535) reach = 65535;
      floor_mm = int'(seg_cfg.min_range_mm);
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
         pt.range_mm = RANGE_W'($urandom_range(0, 65535));
         pt.quality = QUAL_W'($urandom_range(0, 15));
         pt.point_valid = 1'($urandom_range(0, 1));
         return pt;
      end
      if (roll < 76) begin
         walk_range = walk_range + int'($urandom_range(0, 300)) - 150;
         if (walk_range < floor_mm || walk_range > reach)
            walk_range = int'($urandom_range(floor_mm, reach));
      end else if (roll < 94) begin
         step = int'($urandom_range(250, 1500));
         walk_range = $urandom_range(0, 1) ? walk_range + step : walk_range - step;
      end else begin
         walk_range = $urandom_range(0, 1) ? reach + int'($urandom_range(0, 400)) : 0;
      end
      if (walk_range < 0) walk_range = 0;
      if (walk_range > 65535) walk_range = 65535;
      if ($urandom_range(0, 3) == 0) walk_rough = !walk_rough;
      lvl = int'(seg_cfg.rough_level);
      pt.range_mm = RANGE_W'(walk_range);
      if (walk_rough || lvl == 0) pt.quality = QUAL_W'($urandom_range(lvl, 15));
      else pt.quality = QUAL_W'($urandom_range(0, lvl - 1));
      pt.point_valid = ($urandom_range(0, 14) != 0);
      return pt;
   endfunction

   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_segments.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input sos_reg_type r, input logic [15:0] v);
      wait_for_results();
      // a point with no result may still be in the pipe
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= r;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      case (r)
         REG_MAX_RANGE_RIGHT: seg_cfg.max_range_right_mm = v;
         REG_MAX_RANGE_LEFT:  seg_cfg.max_range_left_mm = v;
         REG_SEARCH_EXT:      seg_cfg.search_extension_mm = v;
         REG_MIN_RANGE:       seg_cfg.min_range_mm = v;
         REG_OUTDOOR_MODE:    seg_cfg.outdoor_mode = v[0];
         REG_HORIZONTAL_SCAN: seg_cfg.horizontal_scan = v[0];
         REG_ROUGH_LEVEL:     seg_cfg.rough_level = v[QUAL_W-1:0];
         REG_POINT_COUNT:     seg_cfg.point_count = v[CNT_W-1:0];
         default: ;
      endcase
   endtask

   // offers one point, and on its transfer queues what it should produce
   task automatic send_point(input sos_req_type pt, input int typed_n,
                             input sos_rsp_type typed_seg);
      int gap, n;
      gap = sender_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= pt;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      segment_point(pt, n);
      if (typed_n == FROM_MODEL) begin
         for (int k = 0; k < n; k++) expected_segments.push_back(seg_buf[k]);
      end else if (typed_n > 0) begin
         expected_segments.push_back(typed_seg);
      end
      points_sent++;
   endtask

   task automatic add_csr_row(input sos_reg_type r, input int v);
      stim_row_type row;
      row = '0;
      row.kind = ROW_CSR;
      row.csr = r;
      row.value = 16'(v);
      directed_rows.push_back(row);
   endtask

   task automatic add_point_row(input int rng, input int q, input bit v, input int n,
                                input int first, input int last, input logic kind);
      stim_row_type row;
      row = '0;
      row.kind = ROW_POINT;
      row.pt.range_mm = RANGE_W'(rng);
      row.pt.quality = QUAL_W'(q);
      row.pt.point_valid = v;
      row.typed_n = n;
      row.typed_seg = segment(IDX_W'(first), IDX_W'(last), kind);
      row.typed_seg.last_of_run = 1'b1;
      directed_rows.push_back(row);
   endtask

   // result checker
   always @(posedge clock) begin : result_check
      sos_rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_segments.size() == 0) begin
            report_mismatch($sformatf("unexpected result %0d..%0d kind %0d",
                                      rsp_data.first_index, rsp_data.last_index,
                                      rsp_data.kind));
         end else begin
            want = expected_segments.pop_front();
            if (rsp_data.first_index !== want.first_index)
               report_mismatch($sformatf("first_index got %0d want %0d",
                                         rsp_data.first_index, want.first_index));
            if (rsp_data.last_index !== want.last_index)
               report_mismatch($sformatf("last_index got %0d want %0d",
                                         rsp_data.last_index, want.last_index));
            if (rsp_data.kind !== want.kind)
               report_mismatch($sformatf("kind got %0d want %0d", rsp_data.kind, want.kind));
            if (rsp_data.last_of_run !== want.last_of_run)
               report_mismatch($sformatf("last_of_run got %0d want %0d",
                                         rsp_data.last_of_run, want.last_of_run));
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("scan_obstacle_segmenter regression: fail");
            $finish;
         end
      end
   end

   // result side back-pressure
   initial begin : result_sink
      int burst, pause;
      rsp_stall = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            burst = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 6);
            pause = pick_gap();
            rsp_stall <= 1'b0;
            repeat (burst) @(posedge clock);
            if (pause > 0) begin
               rsp_stall <= 1'b1;
               repeat (pause) @(posedge clock);
            end
         end
      end
   end

   initial begin : stimulus
      int points, roll, cnt;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = REG_MAX_RANGE_RIGHT;
      csr_wdata = '0;

      seg_cfg = '0;
      seg_cfg.max_range_right_mm = RST_MAX_RANGE_MM;
      seg_cfg.max_range_left_mm = RST_MAX_RANGE_MM;
      seg_cfg.rough_level = RST_ROUGH_LEVEL;
      seg_cfg.point_count = RST_POINT_COUNT;
      scan_pos = '0;
      run_first = '0;
      run_open = 1'b0;
      last_range = '0;
      last_quality = '0;

      // indoor defaults: range jump, out of range, invalid point
      add_point_row(1000, 3, 1'b1, 0, 0, 0, KIND_OBSTACLE);
      add_point_row(1100, 3, 1'b1, 0, 0, 0, KIND_OBSTACLE);
      add_point_row(1400, 3, 1'b1, 1, 0, 1, KIND_OBSTACLE);
      add_point_row(65535, 15, 1'b1, 1, 2, 2, KIND_OBSTACLE);
      add_point_row(0, 0, 1'b0, 0, 0, 0, KIND_OBSTACLE);
      add_point_row(500, 2, 1'b1, 0, 0, 0, KIND_OBSTACLE);
      add_point_row(500, 2, 1'b0, 1, 5, 5, KIND_OBSTACLE);
      add_point_row(600, 4, 1'b1, 0, 0, 0, KIND_OBSTACLE);
      // count lowered under the running index: next point ends the scan
      add_csr_row(REG_POINT_COUNT, 3);
      add_point_row(600, 4, 1'b1, FROM_MODEL, 0, 0, KIND_OBSTACLE);
      // outdoor ditch edges on a six point scan
      add_csr_row(REG_OUTDOOR_MODE, 1);
      add_csr_row(REG_POINT_COUNT, 6);
      add_point_row(2000, 0, 1'b1, 0, 0, 0, KIND_OBSTACLE);
      add_point_row(2700, 0, 1'b1, 1, 0, 1, KIND_DITCH);
      add_point_row(2000, 0, 1'b1, 1, 1, 2, KIND_DITCH);
      add_point_row(2000, 5, 1'b1, 0, 0, 0, KIND_OBSTACLE);
      add_point_row(1000, 5, 1'b1, 1, 3, 3, KIND_OBSTACLE);
      add_point_row(1000, 0, 1'b1, 1, 4, 4, KIND_OBSTACLE);
      // zero count means one point per scan
      add_csr_row(REG_POINT_COUNT, 0);
      add_point_row(3000, 9, 1'b1, 1, 0, 0, KIND_OBSTACLE);
      add_point_row(0, 9, 1'b1, 0, 0, 0, KIND_OBSTACLE);
      add_point_row(65535, 15, 1'b1, 0, 0, 0, KIND_OBSTACLE);
      // register extremes, count above the maximum
      add_csr_row(REG_MAX_RANGE_RIGHT, 0);
      add_csr_row(REG_MAX_RANGE_LEFT, 65535);
      add_csr_row(REG_SEARCH_EXT, 65535);
      add_csr_row(REG_MIN_RANGE, 65535);
      add_csr_row(REG_HORIZONTAL_SCAN, 1);
      add_csr_row(REG_ROUGH_LEVEL, 0);
      add_csr_row(REG_POINT_COUNT, 2047);
      add_point_row(65535, 0, 1'b1, FROM_MODEL, 0, 0, KIND_OBSTACLE);
      add_point_row(1, 8, 1'b0, FROM_MODEL, 0, 0, KIND_OBSTACLE);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[k]) begin
         if (directed_rows[k].kind == ROW_CSR)
            write_csr(directed_rows[k].csr, directed_rows[k].value);
         else
            send_point(directed_rows[k].pt, directed_rows[k].typed_n,
                       directed_rows[k].typed_seg);
      end

      // long result hold-off while every point but a scan's first closes an interval
      write_csr(REG_MAX_RANGE_RIGHT, 16'd8000);
      write_csr(REG_MAX_RANGE_LEFT, 16'd8000);
      write_csr(REG_SEARCH_EXT, 16'd0);
      write_csr(REG_MIN_RANGE, 16'd0);
      write_csr(REG_OUTDOOR_MODE, 16'd0);
      write_csr(REG_HORIZONTAL_SCAN, 16'd0);
      write_csr(REG_ROUGH_LEVEL, 16'd1);
      write_csr(REG_POINT_COUNT, 16'd12);
      sender_steady = 1'b1;
      hold_request = 1'b1;
      while (hold_request) @(posedge clock);
      for (int k = 0; k < 36; k++)
         send_point('{range_mm: (k % 2) ? 16'd1600 : 16'd1000, quality: 4'd5,
                      point_valid: 1'b1}, FROM_MODEL, '0);

      while (points_sent < TARGET_POINTS) begin
         write_csr(REG_MAX_RANGE_RIGHT, pick_limit());
         write_csr(REG_MAX_RANGE_LEFT, pick_limit());
         roll = $urandom_range(0, 9);
         write_csr(REG_SEARCH_EXT, (roll < 6) ? 16'd0 : (roll == 6) ? 16'hFFFF
                                              : 16'($urandom_range(0, 2000)));
         roll = $urandom_range(0, 9);
         write_csr(REG_MIN_RANGE, (roll < 5) ? 16'd0 : (roll < 9) ? 16'($urandom_range(0, 800))
                                             : 16'($urandom_range(0, 65535)));
         write_csr(REG_OUTDOOR_MODE, 16'($urandom_range(0, 1)));
         write_csr(REG_HORIZONTAL_SCAN, 16'($urandom_range(0, 3) == 0));
         write_csr(REG_ROUGH_LEVEL, ($urandom_range(0, 6) == 0) ? 16'($urandom_range(0, 15))
                                                               : 16'($urandom_range(1, 4)));
         roll = $urandom_range(0, 9);
         if (roll < 7) cnt = $urandom_range(1, 40);
         else if (roll == 7) cnt = 0;
         else if (roll == 8) cnt = $urandom_range(41, 200);
         else cnt = $urandom_range(0, 1) ? 2047 : 1024;
         write_csr(REG_POINT_COUNT, 16'(cnt));
         sender_steady = ($urandom_range(0, 3) == 0);
         points = $urandom_range(8, 40);
         for (int k = 0; k < points; k++) begin
            if ($urandom_range(0, 29) == 0) wait_for_results();
            send_point(next_scan_point(), FROM_MODEL, '0);
         end
      end

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("scan_obstacle_segmenter regression: pass");
      else
         $display("scan_obstacle_segmenter regression: fail");
      $finish;
   end

endmodule
